@@ rtl/core/diff_drive_move_controller_core_assert.svh @@
// Assertion macros used by the move controller top level.
`ifndef DIFF_DRIVE_MOVE_CONTROLLER_CORE_ASSERT_SVH
`define DIFF_DRIVE_MOVE_CONTROLLER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define DDMC_ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ddmc assertion failed");

// Next-cycle implication, disabled during reset.
`define DDMC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ddmc assertion failed");

`endif

@@ rtl/core/ddmc_pkg.sv @@
// Types and constants of the two-wheel move controller.
package ddmc_pkg;

    localparam logic [1:0] OP_TICK     = 2'd0;
    localparam logic [1:0] OP_STRAIGHT = 2'd1;
    localparam logic [1:0] OP_TURN     = 2'd2;

    localparam logic [1:0] MODE_IDLE     = 2'd0;
    localparam logic [1:0] MODE_STRAIGHT = 2'd1;
    localparam logic [1:0] MODE_TURN     = 2'd2;

    localparam logic [2:0] REG_LEFT_DRIVE = 3'd0;
    localparam logic [2:0] REG_RIGHT_FAST = 3'd1;
    localparam logic [2:0] REG_RIGHT_SLOW = 3'd2;
    localparam logic [2:0] REG_TURN_TICKS = 3'd3;
    localparam logic [2:0] REG_PWM_PERIOD = 3'd4;

    localparam int CFG_DATA_W = 12;
    localparam int GOAL_W     = 27;

    // Turn goal is angle * ticks / 360 / 2, i.e. a floor divide by 720.
    localparam logic [GOAL_W-1:0] TURN_DIV = GOAL_W'(720);

    localparam logic [6:0]  RST_LEFT_DRIVE = 7'd35;
    localparam logic [6:0]  RST_RIGHT_FAST = 7'd40;
    localparam logic [6:0]  RST_RIGHT_SLOW = 7'd30;
    localparam logic [11:0] RST_TURN_TICKS = 12'd465;
    localparam logic [9:0]  RST_PWM_PERIOD = 10'd100;

    typedef struct packed {
        logic [6:0]  left_drive;
        logic [6:0]  right_fast;
        logic [6:0]  right_slow;
        logic [11:0] turn_ticks;
        logic [9:0]  pwm_period;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic        left_a;
        logic        left_b;
        logic        right_a;
        logic        right_b;
        logic [14:0] target_value;
    } item_t;

    typedef struct packed {
        logic [9:0]         left_width;
        logic               left_reverse;
        logic [9:0]         right_width;
        logic               right_reverse;
        logic               move_done;
        logic               busy_res;
        logic signed [15:0] left_ticks;
        logic signed [15:0] right_ticks;
    } result_t;

endpackage

@@ rtl/core/ddmc_engine.sv @@
// Encoder counters, move state and drive mapping for one transaction.
module ddmc_engine (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  ddmc_pkg::cfg_t   cfg,
    input  ddmc_pkg::item_t  item,
    output ddmc_pkg::result_t result
);
    import ddmc_pkg::*;

    logic [15:0]       left_count_reg, left_count_next;
    logic [15:0]       right_count_reg, right_count_next;
    logic              left_a_prev_reg, right_a_prev_reg;
    logic [1:0]        mode_reg, mode_next;
    logic [GOAL_W-1:0] goal_reg, goal_next;

    logic              is_start;
    logic [15:0]       left_tick, right_tick;
    logic [15:0]       left_inc;
    logic [GOAL_W-1:0] left_scaled;
    logic              reached;
    logic              done;
    logic signed [16:0] lc_ext, rc_ext, rc_neg;
    logic              lead;
    logic [6:0]        right_mag;
    logic [9:0]        rev_width;

    always_comb
    begin
        case (item.opcode)
            OP_STRAIGHT: is_start = 1'b1;
            OP_TURN:     is_start = 1'b1;
            default:     is_start = 1'b0;
        endcase
    end

    always_comb
    begin
        left_tick = left_count_reg;
        if (item.left_a && !left_a_prev_reg)
        begin
            left_tick = item.left_b ? left_count_reg - 16'd1 : left_count_reg + 16'd1;
        end
        right_tick = right_count_reg;
        if (item.right_a && !right_a_prev_reg)
        begin
            right_tick = item.right_b ? right_count_reg + 16'd1 : right_count_reg - 16'd1;
        end
    end

    // lc >= floor(P / 720) with lc >= 0 holds when (lc + 1) * 720 > P.
    assign left_inc    = {1'b0, left_tick[14:0]} + 16'd1;
    assign left_scaled = GOAL_W'(left_inc) * TURN_DIV;

    always_comb
    begin
        case (mode_reg)
            MODE_STRAIGHT: reached = !left_tick[15] && (left_tick[14:0] >= goal_reg[14:0]);
            MODE_TURN:     reached = !left_tick[15]
                                     && ((&left_tick[14:0]) || (left_scaled > goal_reg));
            default:       reached = 1'b0;
        endcase
    end

    always_comb
    begin
        done             = 1'b0;
        mode_next        = mode_reg;
        goal_next        = goal_reg;
        left_count_next  = left_tick;
        right_count_next = right_tick;
        if (is_start)
        begin
            left_count_next  = 16'd0;
            right_count_next = 16'd0;
            if (item.opcode == OP_STRAIGHT)
            begin
                mode_next = MODE_STRAIGHT;
                goal_next = GOAL_W'(item.target_value);
            end
            else
            begin
                mode_next = MODE_TURN;
                goal_next = GOAL_W'(item.target_value) * GOAL_W'(cfg.turn_ticks);
            end
        end
        else if (reached)
        begin
            mode_next = MODE_IDLE;
            done      = 1'b1;
        end
    end

    assign lc_ext = {left_count_next[15], left_count_next};
    assign rc_ext = {right_count_next[15], right_count_next};
    assign rc_neg = -rc_ext;

    always_comb
    begin
        case (mode_next)
            MODE_TURN: lead = lc_ext > rc_neg;
            default:   lead = lc_ext > rc_ext;
        endcase
    end

    assign right_mag = lead ? cfg.right_fast : cfg.right_slow;
    assign rev_width = (10'(right_mag) > cfg.pwm_period)
                       ? 10'd0 : cfg.pwm_period - 10'(right_mag);

    always_comb
    begin
        result.left_width    = 10'd0;
        result.left_reverse  = 1'b0;
        result.right_width   = 10'd0;
        result.right_reverse = 1'b0;
        case (mode_next)
            MODE_STRAIGHT:
            begin
                result.left_width  = 10'(cfg.left_drive);
                result.right_width = 10'(right_mag);
            end
            MODE_TURN:
            begin
                result.left_width    = 10'(cfg.left_drive);
                result.right_width   = rev_width;
                result.right_reverse = 1'b1;
            end
            default:
            begin
                result.left_width = 10'd0;
            end
        endcase
        result.move_done   = done;
        result.busy_res    = (mode_next != MODE_IDLE);
        result.left_ticks  = left_count_next;
        result.right_ticks = right_count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_count_reg   <= 16'd0;
            right_count_reg  <= 16'd0;
            left_a_prev_reg  <= 1'b0;
            right_a_prev_reg <= 1'b0;
            mode_reg         <= MODE_IDLE;
            goal_reg         <= '0;
        end
        else if (advance)
        begin
            left_count_reg   <= left_count_next;
            right_count_reg  <= right_count_next;
            left_a_prev_reg  <= item.left_a;
            right_a_prev_reg <= item.right_a;
            mode_reg         <= mode_next;
            goal_reg         <= goal_next;
        end
    end

endmodule

@@ rtl/core/diff_drive_move_controller_core.sv @@
// Top level of the two-wheel move controller: handshake, registers and result stage.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+--------------------------------------------
//   in       | in_valid / in_ready      | opcode, left_a, left_b, right_a, right_b,
//            |                          | target_value
//   out      | out_valid / out_ready    | left_width, left_reverse, right_width,
//            |                          | right_reverse, move_done, busy_res,
//            |                          | left_ticks, right_ticks
//   cfg      | cfg_we                   | cfg_index, cfg_data
//
// One transaction per cycle sustained while out_ready stays high; each passes the input stage, then the result stage.
// The counter, compare and drive logic sits between the input and result registers.
// Reset is asynchronous; it clears counts, move state and the configuration to defaults.
// With out_ready low the result holds, the input stage fills, then in_ready drops.
module diff_drive_move_controller_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             opcode,
    input  logic                   left_a,
    input  logic                   left_b,
    input  logic                   right_a,
    input  logic                   right_b,
    input  logic [14:0]            target_value,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [9:0]             left_width,
    output logic                   left_reverse,
    output logic [9:0]             right_width,
    output logic                   right_reverse,
    output logic                   move_done,
    output logic                   busy_res,
    output logic signed [15:0]     left_ticks,
    output logic signed [15:0]     right_ticks,
    input  logic                   cfg_we,
    input  logic [2:0]             cfg_index,
    input  logic [ddmc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ddmc_pkg::*;

    `include "diff_drive_move_controller_core_assert.svh"

    cfg_t    cfg_reg;
    item_t   item_reg;
    result_t result_reg;
    result_t step_result;
    logic    s1_valid_reg, s1_valid_next;
    logic    out_valid_reg, out_valid_next;
    logic    out_free;
    logic    advance;
    logic    in_take;

    assign out_free = !out_valid_reg || out_ready;
    assign advance  = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || out_free;
    assign in_take  = in_valid && in_ready;

    assign s1_valid_next  = in_take ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.left_drive <= RST_LEFT_DRIVE;
            cfg_reg.right_fast <= RST_RIGHT_FAST;
            cfg_reg.right_slow <= RST_RIGHT_SLOW;
            cfg_reg.turn_ticks <= RST_TURN_TICKS;
            cfg_reg.pwm_period <= RST_PWM_PERIOD;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LEFT_DRIVE: cfg_reg.left_drive <= cfg_data[6:0];
                REG_RIGHT_FAST: cfg_reg.right_fast <= cfg_data[6:0];
                REG_RIGHT_SLOW: cfg_reg.right_slow <= cfg_data[6:0];
                REG_TURN_TICKS: cfg_reg.turn_ticks <= cfg_data[11:0];
                REG_PWM_PERIOD: cfg_reg.pwm_period <= cfg_data[9:0];
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.opcode       <= opcode;
            item_reg.left_a       <= left_a;
            item_reg.left_b       <= left_b;
            item_reg.right_a      <= right_a;
            item_reg.right_b      <= right_b;
            item_reg.target_value <= target_value;
        end
        if (advance)
        begin
            result_reg <= step_result;
        end
    end

    ddmc_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .cfg     (cfg_reg),
        .item    (item_reg),
        .result  (step_result)
    );

    assign out_valid     = out_valid_reg;
    assign left_width    = result_reg.left_width;
    assign left_reverse  = result_reg.left_reverse;
    assign right_width   = result_reg.right_width;
    assign right_reverse = result_reg.right_reverse;
    assign move_done     = result_reg.move_done;
    assign busy_res      = result_reg.busy_res;
    assign left_ticks    = result_reg.left_ticks;
    assign right_ticks   = result_reg.right_ticks;

    `DDMC_ASSERT_SAME(a_done_ends_move, clk, rst_n, out_valid_reg && result_reg.move_done, !result_reg.busy_res && (result_reg.left_width == 10'd0))
    `DDMC_ASSERT_SAME(a_idle_no_drive, clk, rst_n, out_valid_reg && !result_reg.busy_res, (result_reg.right_width == 10'd0) && !result_reg.right_reverse && !result_reg.left_reverse)
    `DDMC_ASSERT_NEXT(a_stage_holds, clk, rst_n, s1_valid_reg && !out_free, s1_valid_reg && $stable(item_reg))
    `DDMC_ASSERT_SAME(a_ready_when_empty, clk, rst_n, !s1_valid_reg, in_ready)

endmodule
